>>> design/fir_convolution_filter_macros.svh
// ----------------------------------------------------------------------------
// fir_convolution_filter_macros.svh
// Assertion macros used by the FIR filter RTL.
// ----------------------------------------------------------------------------
`ifndef FIR_CONVOLUTION_FILTER_MACROS_SVH
`define FIR_CONVOLUTION_FILTER_MACROS_SVH

// same-cycle implication, clocked on clk, off during reset
`define FCF_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, clocked on clk, off during reset
`define FCF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> design/fcf_pkg.sv
// ----------------------------------------------------------------------------
// fcf_pkg
// Types and constants for the FIR convolution filter.
// ----------------------------------------------------------------------------
package fcf_pkg;

    localparam int MAX_TAPS        = 64;
    localparam int SAMPLE_BITS     = 16;
    localparam int COEF_BITS       = 16;
    localparam int OUT_BITS        = 37;
    localparam int TAP_COUNT_BITS  = 7;
    localparam int INDEX_BITS      = 6;
    localparam int PROD_BITS       = COEF_BITS + SAMPLE_BITS;
    localparam int CNT_BITS        = $clog2(MAX_TAPS + 2);

    localparam logic [TAP_COUNT_BITS-1:0] TAP_COUNT_RESET = 7'd64;

    localparam logic OP_COEF   = 1'b0;
    localparam logic OP_SAMPLE = 1'b1;

    typedef logic signed [SAMPLE_BITS-1:0] sample_t;
    typedef logic signed [COEF_BITS-1:0]   coef_t;
    typedef logic signed [PROD_BITS-1:0]   prod_t;
    typedef logic signed [OUT_BITS-1:0]    acc_t;
    typedef logic [CNT_BITS-1:0]           cnt_t;

    localparam cnt_t DONE_CNT = cnt_t'(MAX_TAPS + 1);

    typedef enum logic {
        ST_IDLE,
        ST_RUN
    } state_t;

    typedef struct packed {
        logic shift;
        logic clear;
        logic coef_we;
        logic tap_en;
    } cell_ctl_t;

endpackage

>>> design/fcf_cell.sv
// ----------------------------------------------------------------------------
// fcf_cell
// One tap of the filter: holds a coefficient and a history sample, passes the
// sample and a running sum of products on to the next tap.
// ----------------------------------------------------------------------------
module fcf_cell (
    input  logic              clk,
    input  logic              rst_n,
    input  fcf_pkg::cell_ctl_t ctl,
    input  fcf_pkg::coef_t    coef_in,
    input  fcf_pkg::sample_t  smp_in,
    input  fcf_pkg::acc_t     psum_in,
    output fcf_pkg::sample_t  smp_out,
    output fcf_pkg::acc_t     psum_out
);

    fcf_pkg::coef_t   coef_reg;
    fcf_pkg::sample_t smp_reg;
    fcf_pkg::prod_t   prod_reg;
    fcf_pkg::prod_t   prod_next;
    fcf_pkg::acc_t    psum_reg;
    fcf_pkg::acc_t    psum_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coef_reg <= '0;
            smp_reg  <= '0;
        end
        else
        begin
            if (ctl.coef_we)
            begin
                coef_reg <= coef_in;
            end
            if (ctl.shift)
            begin
                smp_reg <= ctl.clear ? '0 : smp_in;
            end
        end
    end

    always_comb
    begin
        prod_next = ctl.tap_en ? fcf_pkg::prod_t'(coef_reg * smp_reg) : '0;
        psum_next = psum_in + fcf_pkg::acc_t'(prod_reg);
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= prod_next;
        psum_reg <= psum_next;
    end

    assign smp_out  = smp_reg;
    assign psum_out = psum_reg;

endmodule

>>> design/fir_convolution_filter.sv
// ----------------------------------------------------------------------------
// fir_convolution_filter
// Direct-form FIR filter built as a row of tap cells with a loadable
// coefficient per tap and a running sum that ripples down the row.
// ----------------------------------------------------------------------------
//  channel  | signals                                   | role
//  ---------+-------------------------------------------+---------------------
//  in       | in_valid in_ready op coef_index           | coef write or sample
//           | coef_value sample block_start             |
//  out      | out_valid out_ready filtered              | one beat per sample
//  cfg      | cfg_valid cfg_ready tap_count             | taps in use
//
//  A coefficient beat is written straight into its tap cell. A sample beat
//  starts a run: the sum passes the product register and then each tap
//  cell in turn to reach the end of the row, and is then loaded as output.
//  Reset: coefficients and history zero, tap_count 64, available at once.
//  A stalled output beat holds the row; in_ready stays low until it loads.
// ----------------------------------------------------------------------------
`include "fir_convolution_filter_macros.svh"

module fir_convolution_filter (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  op,
    input  logic [fcf_pkg::INDEX_BITS-1:0]        coef_index,
    input  logic signed [fcf_pkg::COEF_BITS-1:0]  coef_value,
    input  logic signed [fcf_pkg::SAMPLE_BITS-1:0] sample,
    input  logic                                  block_start,
    output logic                                  out_valid,
    input  logic                                  out_ready,
    output logic signed [fcf_pkg::OUT_BITS-1:0]   filtered,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [fcf_pkg::TAP_COUNT_BITS-1:0]    tap_count
);

    fcf_pkg::state_t                       state_reg;
    fcf_pkg::state_t                       state_next;
    fcf_pkg::cnt_t                         cnt_reg;
    fcf_pkg::cnt_t                         cnt_next;
    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    fcf_pkg::acc_t                         filtered_reg;
    fcf_pkg::acc_t                         filtered_next;
    logic [fcf_pkg::TAP_COUNT_BITS-1:0]    tap_count_reg;

    logic smp_acc;
    logic coef_acc;

    fcf_pkg::cell_ctl_t ctl     [fcf_pkg::MAX_TAPS];
    fcf_pkg::sample_t   smp_ch  [fcf_pkg::MAX_TAPS];
    fcf_pkg::acc_t      psum_ch [fcf_pkg::MAX_TAPS];

    assign in_ready  = (state_reg == fcf_pkg::ST_IDLE);
    assign cfg_ready = 1'b1;
    assign smp_acc   = in_valid && in_ready && (op == fcf_pkg::OP_SAMPLE);
    assign coef_acc  = in_valid && in_ready && (op == fcf_pkg::OP_COEF);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= fcf_pkg::TAP_COUNT_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            tap_count_reg <= tap_count;
        end
    end

    genvar k;
    generate
        for (k = 0; k < fcf_pkg::MAX_TAPS; k++)
        begin : g_tap
            assign ctl[k].shift   = smp_acc;
            assign ctl[k].clear   = block_start && (k != 0);
            assign ctl[k].coef_we = coef_acc && (int'(coef_index) == k);
            assign ctl[k].tap_en  = (int'(tap_count_reg) > k);

            if (k == 0)
            begin : g_head
                fcf_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctl      (ctl[k]),
                    .coef_in  (coef_value),
                    .smp_in   (sample),
                    .psum_in  ('0),
                    .smp_out  (smp_ch[k]),
                    .psum_out (psum_ch[k])
                );
            end
            else
            begin : g_body
                fcf_cell u_cell (
                    .clk      (clk),
                    .rst_n    (rst_n),
                    .ctl      (ctl[k]),
                    .coef_in  (coef_value),
                    .smp_in   (smp_ch[k-1]),
                    .psum_in  (psum_ch[k-1]),
                    .smp_out  (smp_ch[k]),
                    .psum_out (psum_ch[k])
                );
            end
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fcf_pkg::ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        filtered_reg <= filtered_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        filtered_next  = filtered_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            fcf_pkg::ST_IDLE:
            begin
                if (smp_acc)
                begin
                    state_next = fcf_pkg::ST_RUN;
                    cnt_next   = '0;
                end
            end
            fcf_pkg::ST_RUN:
            begin
                if (cnt_reg == fcf_pkg::DONE_CNT)
                begin
                    if (!out_valid_reg || out_ready)
                    begin
                        out_valid_next = 1'b1;
                        filtered_next  = psum_ch[fcf_pkg::MAX_TAPS-1];
                        state_next     = fcf_pkg::ST_IDLE;
                    end
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            default:
            begin
                state_next = fcf_pkg::ST_IDLE;
            end
        endcase
    end

    assign out_valid = out_valid_reg;
    assign filtered  = filtered_reg;

    `FCF_ASSERT_NEXT(a_sample_starts_run, smp_acc, state_reg == fcf_pkg::ST_RUN, "sample beat did not start a run")
    `FCF_ASSERT_NEXT(a_coef_stays_idle, coef_acc, state_reg == fcf_pkg::ST_IDLE && !$rose(out_valid_reg), "coefficient beat produced work")
    `FCF_ASSERT_NOW(a_cnt_bound, state_reg == fcf_pkg::ST_RUN, cnt_reg <= fcf_pkg::DONE_CNT, "run counter overran")
    `FCF_ASSERT_NEXT(a_done_loads, state_reg == fcf_pkg::ST_RUN && cnt_reg == fcf_pkg::DONE_CNT && (!out_valid_reg || out_ready), out_valid_reg && state_reg == fcf_pkg::ST_IDLE, "finished sum not loaded")

endmodule

>>> dv/fir_convolution_filter_checker.sv
// ----------------------------------------------------------------------------
// fir_convolution_filter_checker
// Watches the input, output and tap_count channels of the FIR filter, keeps
// its own coefficient store and sample window, and predicts the sum of
// products for every sample beat. Output beats are compared in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fir_convolution_filter_checker
    import fcf_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic                      op,
    input  logic [INDEX_BITS-1:0]     coef_index,
    input  coef_t                     coef_value,
    input  sample_t                   sample,
    input  logic                      block_start,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  acc_t                      filtered,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [TAP_COUNT_BITS-1:0] tap_count,
    output int                        mismatches,
    output int                        pending,
    output int                        outputs_checked
);

    coef_t                     coef_mem [MAX_TAPS];
    sample_t                   window [MAX_TAPS];
    logic [TAP_COUNT_BITS-1:0] taps_in_use;
    acc_t                      expected_sums [$];

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH: %s", $time, msg);
        mismatches++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin : predict_and_compare
        longint total;
        int     used;
        acc_t   want;
        if (!rst_n)
        begin
            foreach (coef_mem[k])
            begin
                coef_mem[k] = '0;
                window[k]   = '0;
            end
            taps_in_use = TAP_COUNT_RESET;
            expected_sums.delete();
            pending         = 0;
            mismatches      = 0;
            outputs_checked = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                taps_in_use = tap_count;
            if (in_valid && in_ready)
            begin
                if (op == OP_COEF)
                    coef_mem[coef_index] = coef_value;
                else
                begin
                    if (block_start)
                        foreach (window[k])
                            window[k] = '0;
                    for (int k = MAX_TAPS - 1; k > 0; k--)
                        window[k] = window[k-1];
                    window[0] = sample;
                    used  = (taps_in_use > MAX_TAPS) ? MAX_TAPS : int'(taps_in_use);
                    total = 0;
                    for (int k = 0; k < used; k++)
                        total += longint'(coef_mem[k]) * longint'(window[k]);
                    expected_sums.push_back(acc_t'(total));
                end
            end
            if (out_valid && out_ready)
            begin
                if (expected_sums.size() == 0)
                    report_mismatch($sformatf("filtered %0d with no sample pending",
                                              filtered));
                else
                begin
                    want = expected_sums.pop_front();
                    if (filtered !== want)
                        report_mismatch($sformatf("filtered %0d, expected %0d (beat %0d)",
                                                  filtered, want, outputs_checked));
                    outputs_checked++;
                end
            end
            pending = expected_sums.size();
        end
    end

endmodule

>>> dv/tb_fir_convolution_filter.sv
// ----------------------------------------------------------------------------
// tb_fir_convolution_filter
// Drives coefficient loads, sample streams and tap_count settings into the
// FIR filter with random gaps and output stalls; the checker beside the
// block predicts every filtered beat and counts mismatches.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_fir_convolution_filter;
    import fcf_pkg::*;

    localparam int SETTLE_CYCLES = MAX_TAPS + 3 + 13;
    localparam int STALL_LIMIT   = 2000;
    localparam int PHASE_ITEMS   = 140;

    typedef struct {
        logic                  op;
        logic [INDEX_BITS-1:0] index;
        coef_t                 coef;
        sample_t               value;
        logic                  start;
    } filter_item_t;

    logic                      clk = 1'b0;
    logic                      rst_n;
    logic                      in_valid;
    logic                      in_ready;
    logic                      op;
    logic [INDEX_BITS-1:0]     coef_index;
    coef_t                     coef_value;
    sample_t                   sample;
    logic                      block_start;
    logic                      out_valid;
    logic                      out_ready;
    acc_t                      filtered;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [TAP_COUNT_BITS-1:0] tap_count;

    int mismatches;
    int pending;
    int outputs_checked;
    int idle_cycles = 0;
    int coef_loads  = 0;
    int samples_sent = 0;
    int cfg_writes  = 0;
    bit quiet       = 1'b0;

    fir_convolution_filter dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .op          (op),
        .coef_index  (coef_index),
        .coef_value  (coef_value),
        .sample      (sample),
        .block_start (block_start),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .filtered    (filtered),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .tap_count   (tap_count)
    );

    fir_convolution_filter_checker u_check (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .coef_index      (coef_index),
        .coef_value      (coef_value),
        .sample          (sample),
        .block_start     (block_start),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .filtered        (filtered),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .tap_count       (tap_count),
        .mismatches      (mismatches),
        .pending         (pending),
        .outputs_checked (outputs_checked)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic sample_t pick_word();
        case ($urandom_range(0, 7))
            0:       return sample_t'(16'h8000);
            1:       return sample_t'(16'h7fff);
            2:       return sample_t'(16'h0000);
            3:       return sample_t'(16'hffff);
            default: return sample_t'($urandom);
        endcase
    endfunction

    function automatic filter_item_t coef_item(input int idx, input int val);
        filter_item_t it;
        it.op    = OP_COEF;
        it.index = idx[INDEX_BITS-1:0];
        it.coef  = coef_t'(val);
        it.value = sample_t'($urandom);
        it.start = 1'($urandom);
        return it;
    endfunction

    function automatic filter_item_t sample_item(input int val, input bit start);
        filter_item_t it;
        it.op    = OP_SAMPLE;
        it.index = INDEX_BITS'($urandom);
        it.coef  = coef_t'($urandom);
        it.value = sample_t'(val);
        it.start = start;
        return it;
    endfunction

    task automatic send_beat(input filter_item_t it);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 14);
        if (gap > 0)
        begin
            in_valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        op          = it.op;
        coef_index  = it.index;
        coef_value  = it.coef;
        sample      = it.value;
        block_start = it.start;
        in_valid    = 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        @(negedge clk);
        if (it.op == OP_COEF)
            coef_loads++;
        else
            samples_sent++;
    endtask

    task automatic hold_until_drained();
        in_valid = 1'b0;
        while (pending != 0) @(negedge clk);
    endtask

    task automatic write_tap_count(input logic [TAP_COUNT_BITS-1:0] taps);
        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        tap_count = taps;
        cfg_valid = 1'b1;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid = 1'b0;
        cfg_writes++;
    endtask

    // output side: random stall before each beat
    initial
    begin : result_sink
        int stall;
        while (rst_n !== 1'b1) @(negedge clk);
        forever
        begin
            stall = quiet ? 0 : $urandom_range(0, 14);
            if (stall > 0)
            begin
                out_ready = 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready = 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
            @(negedge clk);
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) ||
            (cfg_valid && cfg_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT)
        begin
            $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                     STALL_LIMIT, pending);
            $display("fir_convolution_filter regression: fail");
            $finish;
        end
    end

    initial
    begin : stimulus
        logic [TAP_COUNT_BITS-1:0] phase_taps [8];
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        op          = OP_SAMPLE;
        coef_index  = '0;
        coef_value  = '0;
        sample      = '0;
        block_start = 1'b0;
        out_ready   = 1'b0;
        cfg_valid   = 1'b0;
        tap_count   = TAP_COUNT_RESET;
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // empty store, then extreme taps and samples
        send_beat(sample_item(32767, 1'b1));
        send_beat(coef_item(0, -32768));
        send_beat(coef_item(63, 32767));
        send_beat(coef_item(1, 1));
        send_beat(coef_item(2, -1));
        send_beat(coef_item(62, 16384));
        send_beat(sample_item(-32768, 1'b1));
        send_beat(sample_item(32767, 1'b0));
        send_beat(sample_item(-1, 1'b0));
        send_beat(sample_item(0, 1'b0));
        send_beat(sample_item(1, 1'b0));
        send_beat(sample_item(12345, 1'b1));
        // zero taps, too many taps, single tap
        write_tap_count(7'd0);
        send_beat(sample_item(-32768, 1'b0));
        send_beat(sample_item(32767, 1'b1));
        write_tap_count(7'd127);
        send_beat(sample_item(-32768, 1'b0));
        send_beat(sample_item(32767, 1'b0));
        write_tap_count(7'd65);
        send_beat(sample_item(-2, 1'b0));
        write_tap_count(7'd1);
        send_beat(sample_item(-32768, 1'b0));
        send_beat(sample_item(32767, 1'b0));

        phase_taps = '{7'd64, 7'd1, 7'd0, 7'd127, 7'd65, 7'd2, 7'd63, 7'd64};
        phase_taps[7] = TAP_COUNT_BITS'($urandom_range(1, MAX_TAPS));
        for (int p = 0; p < 8; p++)
        begin
            write_tap_count(phase_taps[p]);
            quiet = (p == 1 || p == 4);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                if (p == 2 && n == PHASE_ITEMS / 2)
                    hold_until_drained();
                if ($urandom_range(0, 3) == 0)
                    send_beat(coef_item($urandom_range(0, MAX_TAPS - 1), int'(pick_word())));
                else
                    send_beat(sample_item(int'(pick_word()), $urandom_range(0, 23) == 0));
            end
            quiet = 1'b0;
        end

        // every coefficient and sample at its most negative: the full sum wraps
        write_tap_count(7'd64);
        for (int k = 0; k < MAX_TAPS; k++)
            send_beat(coef_item(k, -32768));
        for (int k = 0; k < MAX_TAPS + 6; k++)
            send_beat(sample_item(-32768, k == 0));

        hold_until_drained();
        repeat (SETTLE_CYCLES) @(negedge clk);
        $display("Covered %0d coefficient loads, %0d samples, %0d tap_count writes.",
                 coef_loads, samples_sent, cfg_writes);
        $display("Checked %0d filtered beats, %0d mismatches.", outputs_checked, mismatches);
        if (pending != 0)
            $display("%0d filtered beats never arrived", pending);
        if (mismatches == 0 && pending == 0)
            $display("fir_convolution_filter regression: pass");
        else
            $display("fir_convolution_filter regression: fail");
        $finish;
    end

endmodule

>>> files.f
+incdir+design
design/fcf_pkg.sv
design/fcf_cell.sv
design/fir_convolution_filter.sv
dv/fir_convolution_filter_checker.sv
dv/tb_fir_convolution_filter.sv
